// ===== hw/rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

    // Error kinds carried on a result beat.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX    = 2'd2;

    // Depth of the command queue between the front and back parts.
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] error_kind;
        logic       run_end;
        logic       string_end;
    } out_item_t;

    // One decoded input byte: up to two code points to encode, then a plain
    // byte or an error beat.
    typedef struct packed {
        logic        enc_a_valid;
        logic [20:0] enc_a_cp;
        logic        enc_b_valid;
        logic [15:0] enc_b_cp;
        logic        tail_valid;
        logic [7:0]  tail_byte;
        logic [1:0]  tail_err;
        logic        last;
    } cmd_t;

endpackage

// ===== hw/rtl/jsu_front.sv =====
`timescale 1ns / 1ps

module jsu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  jsu_pkg::in_item_t item,
    output logic              cmd_push,
    output jsu_pkg::cmd_t     cmd
);
    import jsu_pkg::*;

    localparam logic [2:0] PH_PLAIN    = 3'd0;
    localparam logic [2:0] PH_ESC      = 3'd1;
    localparam logic [2:0] PH_HEX1     = 3'd2;
    localparam logic [2:0] PH_HIGH     = 3'd3;
    localparam logic [2:0] PH_HIGH_ESC = 3'd4;
    localparam logic [2:0] PH_HEX2     = 3'd5;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // Returns {valid, value} for one hex digit in either case.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_high(input logic [15:0] cp);
        return (cp >= 16'hD800) && (cp <= 16'hDBFF);
    endfunction

    function automatic logic is_low(input logic [15:0] cp);
        return (cp >= 16'hDC00) && (cp <= 16'hDFFF);
    endfunction

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        swallow_reg, swallow_next;

    logic [7:0]  b;
    logic        last;
    logic [4:0]  hex;
    logic        simple_hit;
    logic [7:0]  simple_val;
    logic [15:0] first_sh;
    logic [15:0] second_sh;
    logic [1:0]  err;
    logic [20:0] pair_cp;

    assign b         = item.in_byte;
    assign last      = item.in_last;
    assign hex       = hex_decode(b);
    assign first_sh  = {first_reg[11:0], hex[3:0]};
    assign second_sh = {second_reg[11:0], hex[3:0]};
    assign pair_cp   = {1'b0, first_reg[9:0], second_sh[9:0]} + 21'h10000;

    always_comb
    begin
        simple_hit = 1'b1;
        case (b)
            8'h22:   simple_val = 8'h22;
            8'h5C:   simple_val = 8'h5C;
            8'h2F:   simple_val = 8'h2F;
            8'h62:   simple_val = 8'h08;
            8'h66:   simple_val = 8'h0C;
            8'h6E:   simple_val = 8'h0A;
            8'h72:   simple_val = 8'h0D;
            8'h74:   simple_val = 8'h09;
            default:
            begin
                simple_val = 8'h00;
                simple_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        cnt_next     = cnt_reg;
        swallow_next = swallow_reg;
        err          = ERR_NONE;
        cmd          = '0;
        cmd.last     = last;

        if (swallow_reg)
        begin
            // Rest of a failed string is dropped.
        end
        else
        begin
            unique case (phase_reg)
                PH_PLAIN:
                begin
                    if (b == CH_BSLASH && !last)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_byte  = b;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_PLAIN;
                    if (b == CH_U && !last)
                    begin
                        phase_next = PH_HEX1;
                        cnt_next   = 2'd0;
                        first_next = 16'd0;
                    end
                    else if (b == CH_U)
                    begin
                        err = ERR_BAD_HEX;
                    end
                    else if (simple_hit)
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_byte  = simple_val;
                    end
                    else
                    begin
                        err = ERR_BAD_ESCAPE;
                    end
                end
                PH_HEX1:
                begin
                    if (!hex[4])
                    begin
                        err = ERR_BAD_HEX;
                    end
                    else
                    begin
                        first_next = first_sh;
                        if (cnt_reg != 2'd3)
                        begin
                            cnt_next = cnt_reg + 2'd1;
                            if (last)
                            begin
                                err = ERR_BAD_HEX;
                            end
                        end
                        else
                        begin
                            cnt_next = 2'd0;
                            if (is_high(first_sh) && !last)
                            begin
                                phase_next = PH_HIGH;
                            end
                            else
                            begin
                                cmd.enc_a_valid = 1'b1;
                                cmd.enc_a_cp    = {5'd0, first_sh};
                                phase_next      = PH_PLAIN;
                            end
                        end
                    end
                end
                PH_HIGH:
                begin
                    if (b == CH_BSLASH && !last)
                    begin
                        phase_next = PH_HIGH_ESC;
                    end
                    else
                    begin
                        cmd.enc_a_valid = 1'b1;
                        cmd.enc_a_cp    = {5'd0, first_reg};
                        cmd.tail_valid  = 1'b1;
                        cmd.tail_byte   = b;
                        phase_next      = PH_PLAIN;
                    end
                end
                PH_HIGH_ESC:
                begin
                    if (b == CH_U && !last)
                    begin
                        phase_next  = PH_HEX2;
                        cnt_next    = 2'd0;
                        second_next = 16'd0;
                    end
                    else
                    begin
                        cmd.enc_a_valid = 1'b1;
                        cmd.enc_a_cp    = {5'd0, first_reg};
                        phase_next      = PH_PLAIN;
                        if (b == CH_U)
                        begin
                            err = ERR_BAD_HEX;
                        end
                        else if (simple_hit)
                        begin
                            cmd.tail_valid = 1'b1;
                            cmd.tail_byte  = simple_val;
                        end
                        else
                        begin
                            err = ERR_BAD_ESCAPE;
                        end
                    end
                end
                PH_HEX2:
                begin
                    if (!hex[4])
                    begin
                        cmd.enc_a_valid = 1'b1;
                        cmd.enc_a_cp    = {5'd0, first_reg};
                        err             = ERR_BAD_HEX;
                    end
                    else
                    begin
                        second_next = second_sh;
                        if (cnt_reg != 2'd3)
                        begin
                            cnt_next = cnt_reg + 2'd1;
                            if (last)
                            begin
                                cmd.enc_a_valid = 1'b1;
                                cmd.enc_a_cp    = {5'd0, first_reg};
                                err             = ERR_BAD_HEX;
                            end
                        end
                        else
                        begin
                            cnt_next        = 2'd0;
                            cmd.enc_a_valid = 1'b1;
                            phase_next      = PH_PLAIN;
                            if (is_low(second_sh))
                            begin
                                cmd.enc_a_cp = pair_cp;
                            end
                            else
                            begin
                                cmd.enc_a_cp = {5'd0, first_reg};
                                if (is_high(second_sh) && !last)
                                begin
                                    first_next = second_sh;
                                    phase_next = PH_HIGH;
                                end
                                else
                                begin
                                    cmd.enc_b_valid = 1'b1;
                                    cmd.enc_b_cp    = second_sh;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next     = PH_PLAIN;
                    cmd.tail_valid = 1'b1;
                    cmd.tail_byte  = b;
                end
            endcase

            if (err != ERR_NONE)
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_byte  = 8'd0;
                cmd.tail_err   = err;
                phase_next     = PH_PLAIN;
                cnt_next       = 2'd0;
                swallow_next   = !last;
            end
        end

        if (last)
        begin
            phase_next   = PH_PLAIN;
            first_next   = 16'd0;
            second_next  = 16'd0;
            cnt_next     = 2'd0;
            swallow_next = 1'b0;
        end
    end

    assign cmd_push = accept && (cmd.enc_a_valid || cmd.enc_b_valid || cmd.tail_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PLAIN;
            first_reg   <= 16'd0;
            second_reg  <= 16'd0;
            cnt_reg     <= 2'd0;
            swallow_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            cnt_reg     <= cnt_next;
            swallow_reg <= swallow_next;
        end
    end

endmodule

// ===== hw/rtl/jsu_cmd_fifo.sv =====
`timescale 1ns / 1ps

module jsu_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  jsu_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output jsu_pkg::cmd_t rd_data,
    output logic          full,
    output logic          not_empty
);
    import jsu_pkg::*;

    cmd_t                 entry_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;

    assign full      = (count_reg == CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];

    function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
        return (p == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/jsu_back.sv =====
`timescale 1ns / 1ps

module jsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_avail,
    input  jsu_pkg::cmd_t      cmd_in,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output jsu_pkg::out_item_t result
);
    import jsu_pkg::*;

    localparam logic [1:0] SEG_A    = 2'd0;
    localparam logic [1:0] SEG_B    = 2'd1;
    localparam logic [1:0] SEG_TAIL = 2'd2;

    // Number of UTF-8 bytes for a code point, minus one.
    function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
        logic [1:0] r;
        if (cp <= 21'h7F)
        begin
            r = 2'd0;
        end
        else if (cp <= 21'h7FF)
        begin
            r = 2'd1;
        end
        else if (cp <= 21'hFFFF)
        begin
            r = 2'd2;
        end
        else
        begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] lm1,
                                             input logic [1:0] idx);
        logic [7:0] r;
        logic [1:0] rest;
        rest = lm1 - idx;
        if (idx == 2'd0)
        begin
            case (lm1)
                2'd0:    r = {1'b0, cp[6:0]};
                2'd1:    r = 8'hC0 | {3'd0, cp[10:6]};
                2'd2:    r = 8'hE0 | {4'd0, cp[15:12]};
                default: r = 8'hF0 | {5'd0, cp[20:18]};
            endcase
        end
        else
        begin
            case (rest)
                2'd0:    r = {2'b10, cp[5:0]};
                2'd1:    r = {2'b10, cp[11:6]};
                default: r = {2'b10, cp[17:12]};
            endcase
        end
        return r;
    endfunction

    cmd_t      cmd_reg, cmd_next;
    logic      cur_valid_reg, cur_valid_next;
    logic [1:0] seg_reg, seg_next;
    logic [1:0] idx_reg, idx_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [20:0] cur_cp;
    logic [1:0]  cur_lm1;
    logic        seg_done;
    logic        has_next_seg;
    logic [1:0]  next_seg;
    logic        cmd_done;
    logic        out_ready;
    logic        emit;
    logic [1:0]  load_seg;

    assign cur_cp  = (seg_reg == SEG_A) ? cmd_reg.enc_a_cp : {5'd0, cmd_reg.enc_b_cp};
    assign cur_lm1 = (seg_reg == SEG_TAIL) ? 2'd0 : utf8_len_m1(cur_cp);
    assign seg_done = (idx_reg == cur_lm1);

    always_comb
    begin
        has_next_seg = 1'b0;
        next_seg     = SEG_TAIL;
        unique case (seg_reg)
            SEG_A:
            begin
                if (cmd_reg.enc_b_valid)
                begin
                    has_next_seg = 1'b1;
                    next_seg     = SEG_B;
                end
                else if (cmd_reg.tail_valid)
                begin
                    has_next_seg = 1'b1;
                end
            end
            SEG_B:
            begin
                has_next_seg = cmd_reg.tail_valid;
            end
            default:
            begin
                has_next_seg = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd_in.enc_a_valid)
        begin
            load_seg = SEG_A;
        end
        else if (cmd_in.enc_b_valid)
        begin
            load_seg = SEG_B;
        end
        else
        begin
            load_seg = SEG_TAIL;
        end
    end

    assign cmd_done  = seg_done && !has_next_seg;
    assign out_ready = !out_valid_reg || pop;
    assign emit      = cur_valid_reg && out_ready;
    assign cmd_pop   = cmd_avail && (!cur_valid_reg || (emit && cmd_done));

    always_comb
    begin
        cmd_next       = cmd_reg;
        cur_valid_next = cur_valid_reg;
        seg_next       = seg_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (seg_reg == SEG_TAIL)
            begin
                out_next.out_byte   = cmd_reg.tail_byte;
                out_next.error_kind = cmd_reg.tail_err;
            end
            else
            begin
                out_next.out_byte   = utf8_byte(cur_cp, cur_lm1, idx_reg);
                out_next.error_kind = ERR_NONE;
            end
            out_next.run_end    = cmd_done;
            out_next.string_end = cmd_done && cmd_reg.last;

            if (!seg_done)
            begin
                idx_next = idx_reg + 2'd1;
            end
            else if (has_next_seg)
            begin
                seg_next = next_seg;
                idx_next = 2'd0;
            end
            else
            begin
                cur_valid_next = 1'b0;
            end
        end

        if (cmd_pop)
        begin
            cmd_next       = cmd_in;
            cur_valid_next = 1'b1;
            seg_next       = load_seg;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            seg_reg       <= SEG_A;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            seg_reg       <= seg_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

// ===== hw/rtl/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// item      in         push / full          in_byte, in_last
// result    out        empty / pop          out_byte, error_kind, run_end, string_end
//
// One input byte is taken per cycle whenever full is low; the front decoder
// classifies it in that same cycle and queues a command for the back part.
// The back part sends one result beat per cycle unless pop stalls it, so a byte
// that causes k results (1 to 6) sends them as k beats; that serializer sets the
// sustained rate. A result passes the command queue, cmd_reg and out_reg in turn.
// Reset clears the decoder state, the command queue and the output register.
// A stall on pop fills the output register, the command being expanded, then
// the two-entry queue, and then raises full.

module json_string_unescape_utf8 (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  jsu_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output jsu_pkg::out_item_t result
);
    import jsu_pkg::*;

    logic accept;
    logic cmd_push;
    cmd_t cmd_front;
    cmd_t cmd_head;
    logic cmd_avail;
    logic cmd_pop;

    // An input beat is taken only when the command queue has room, so the
    // decoder state never advances on a byte whose command could be lost.
    assign accept = push && !full;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd_front)
    );

    // Short queue that lets the decoder run ahead while multi-byte output
    // runs are being drained.
    jsu_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_push),
        .wr_data   (cmd_front),
        .rd_en     (cmd_pop),
        .rd_data   (cmd_head),
        .full      (full),
        .not_empty (cmd_avail)
    );

    // Expands each command into UTF-8 bytes, plain bytes and error beats, one a cycle unless pop stalls.
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd_in    (cmd_head),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== hw/rtl/jsu_checker.sv =====
`timescale 1ns / 1ps

module jsu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input jsu_pkg::in_item_t  item,
    input logic               empty,
    input logic               pop,
    input jsu_pkg::out_item_t result
);
    import jsu_pkg::*;

    // A waiting result is not withdrawn or changed before it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed while stalled");

    // An error beat carries a zero byte, a known kind, and ends its run.
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.error_kind != ERR_NONE) |->
        (result.out_byte == 8'd0 && result.run_end &&
         (result.error_kind == ERR_BAD_ESCAPE || result.error_kind == ERR_BAD_HEX)))
        else $error("malformed error beat");

    // The end of a string is also the end of the run for that byte.
    a_string_end_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.string_end) |-> result.run_end)
        else $error("string_end without run_end");

    // An input beat that is refused stays offered and unchanged.
    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |=> (push && $stable(item)))
        else $error("input beat withdrawn or changed while full");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import jsu_pkg::*;

    // The decoder phases that the predictor walks through.
    typedef enum logic [2:0] {
        DEC_PLAIN,
        DEC_ESC,
        DEC_HEX1,
        DEC_HIGH,
        DEC_HIGH_ESC,
        DEC_HEX2
    } dec_phase_t;

    typedef logic [7:0] byte_q_t[$];

    localparam int MAX_RESULTS = 6;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam int RANDOM_BYTES_PER_PASS = 100;

    // The predictor keeps its own copy of the decoder state. Every accepted raw
    // byte is run through it, and the decoded beats that byte causes are queued
    // in order. Each result beat taken from the block is checked against the
    // oldest queued beat.
    class unescape_scoreboard;
        dec_phase_t  phase;
        logic [15:0] first_code;
        logic [15:0] second_code;
        logic [2:0]  hex_count;
        logic        swallowing;
        out_item_t   step_beats[$];
        out_item_t   decoded_q[$];
        int          failures;
        int          bytes_in;
        int          strings_in;
        int          beats_checked;
        int          error_beats;
        int          four_byte_seqs;

        function new();
            clear_state();
            failures       = 0;
            bytes_in       = 0;
            strings_in     = 0;
            beats_checked  = 0;
            error_beats    = 0;
            four_byte_seqs = 0;
        endfunction

        function void clear_state();
            phase       = DEC_PLAIN;
            first_code  = '0;
            second_code = '0;
            hex_count   = '0;
            swallowing  = 1'b0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void emit(logic [7:0] b, logic [1:0] err);
            out_item_t r;
            if (step_beats.size() >= MAX_RESULTS)
                return;
            r.out_byte   = b;
            r.error_kind = err;
            r.run_end    = 1'b0;
            r.string_end = 1'b0;
            step_beats.insert(step_beats.size(), r);
        endfunction

        function void encode_cp(logic [20:0] cp);
            if (cp <= 21'h7F)
            begin
                emit(cp[7:0], ERR_NONE);
            end
            else if (cp <= 21'h7FF)
            begin
                emit(8'hC0 | cp[10:6], ERR_NONE);
                emit(8'h80 | cp[5:0], ERR_NONE);
            end
            else if (cp <= 21'hFFFF)
            begin
                emit(8'hE0 | cp[15:12], ERR_NONE);
                emit(8'h80 | cp[11:6], ERR_NONE);
                emit(8'h80 | cp[5:0], ERR_NONE);
            end
            else
            begin
                emit(8'hF0 | cp[20:18], ERR_NONE);
                emit(8'h80 | cp[17:12], ERR_NONE);
                emit(8'h80 | cp[11:6], ERR_NONE);
                emit(8'h80 | cp[5:0], ERR_NONE);
                four_byte_seqs++;
            end
        endfunction

        function int hex_val(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return int'(c - 8'h30);
            if (c >= "a" && c <= "f")
                return int'(c - 8'h61) + 10;
            if (c >= "A" && c <= "F")
                return int'(c - 8'h41) + 10;
            return -1;
        endfunction

        function int simple_escape(logic [7:0] c);
            case (c)
                "\"":    return 8'h22;
                "\\":    return 8'h5C;
                "/":     return 8'h2F;
                "b":     return 8'h08;
                "f":     return 8'h0C;
                "n":     return 8'h0A;
                "r":     return 8'h0D;
                "t":     return 8'h09;
                default: return -1;
            endcase
        endfunction

        function logic is_high(logic [15:0] cp);
            return cp >= 16'hD800 && cp <= 16'hDBFF;
        endfunction

        function logic is_low(logic [15:0] cp);
            return cp >= 16'hDC00 && cp <= 16'hDFFF;
        endfunction

        // A complete \u value. A high surrogate waits for a possible low half
        // unless the string ends here.
        function void start_code(logic [15:0] cp, logic last);
            if (is_high(cp) && !last)
            begin
                first_code = cp;
                phase      = DEC_HIGH;
            end
            else
            begin
                encode_cp({5'd0, cp});
                phase = DEC_PLAIN;
            end
        endfunction

        // The character after a backslash that did not end the string.
        function logic [1:0] escape_char(logic [7:0] c);
            int m;
            if (c == CH_U)
                return ERR_BAD_HEX;
            m = simple_escape(c);
            if (m < 0)
                return ERR_BAD_ESCAPE;
            emit(m[7:0], ERR_NONE);
            return ERR_NONE;
        endfunction

        function void note_raw_byte(in_item_t it);
            logic [7:0] b;
            logic       last;
            logic [1:0] err;
            int         h;
            logic [3:0] nib;
            b    = it.in_byte;
            last = it.in_last;
            err  = ERR_NONE;
            step_beats.delete();
            bytes_in++;
            if (last)
                strings_in++;

            // After an escape error the rest of the string is dropped.
            if (swallowing)
            begin
                if (last)
                    clear_state();
                return;
            end

            case (phase)
                DEC_PLAIN:
                begin
                    if (b == CH_BSLASH && !last)
                        phase = DEC_ESC;
                    else
                        emit(b, ERR_NONE);
                end
                DEC_ESC:
                begin
                    phase = DEC_PLAIN;
                    if (b == CH_U && !last)
                    begin
                        phase      = DEC_HEX1;
                        hex_count  = '0;
                        first_code = '0;
                    end
                    else
                    begin
                        err = escape_char(b);
                    end
                end
                DEC_HEX1:
                begin
                    h = hex_val(b);
                    if (h < 0)
                    begin
                        err = ERR_BAD_HEX;
                    end
                    else
                    begin
                        nib        = h[3:0];
                        first_code = {first_code[11:0], nib};
                        hex_count  = hex_count + 3'd1;
                        if (hex_count < 3'd4)
                        begin
                            if (last)
                                err = ERR_BAD_HEX;
                        end
                        else
                        begin
                            hex_count = '0;
                            start_code(first_code, last);
                        end
                    end
                end
                DEC_HIGH:
                begin
                    if (b == CH_BSLASH && !last)
                    begin
                        phase = DEC_HIGH_ESC;
                    end
                    else
                    begin
                        encode_cp({5'd0, first_code});
                        emit(b, ERR_NONE);
                        phase = DEC_PLAIN;
                    end
                end
                DEC_HIGH_ESC:
                begin
                    if (b == CH_U && !last)
                    begin
                        phase       = DEC_HEX2;
                        hex_count   = '0;
                        second_code = '0;
                    end
                    else
                    begin
                        encode_cp({5'd0, first_code});
                        phase = DEC_PLAIN;
                        err   = escape_char(b);
                    end
                end
                DEC_HEX2:
                begin
                    h = hex_val(b);
                    if (h < 0)
                    begin
                        encode_cp({5'd0, first_code});
                        err = ERR_BAD_HEX;
                    end
                    else
                    begin
                        nib         = h[3:0];
                        second_code = {second_code[11:0], nib};
                        hex_count   = hex_count + 3'd1;
                        if (hex_count < 3'd4)
                        begin
                            if (last)
                            begin
                                encode_cp({5'd0, first_code});
                                err = ERR_BAD_HEX;
                            end
                        end
                        else
                        begin
                            hex_count = '0;
                            if (is_low(second_code))
                            begin
                                encode_cp({1'b0, first_code[9:0], second_code[9:0]} +
                                          21'h10000);
                                phase = DEC_PLAIN;
                            end
                            else
                            begin
                                encode_cp({5'd0, first_code});
                                start_code(second_code, last);
                            end
                        end
                    end
                end
                default:
                begin
                    phase = DEC_PLAIN;
                    emit(b, ERR_NONE);
                end
            endcase

            if (err != ERR_NONE)
            begin
                emit(8'h00, err);
                error_beats++;
                phase     = DEC_PLAIN;
                hex_count = '0;
                if (!last)
                    swallowing = 1'b1;
            end
            if (last)
                clear_state();

            if (step_beats.size() > 0)
            begin
                step_beats[step_beats.size() - 1].run_end    = 1'b1;
                step_beats[step_beats.size() - 1].string_end = last;
            end
            foreach (step_beats[i])
                decoded_q.insert(decoded_q.size(), step_beats[i]);
        endfunction

        function void check_decoded_beat(out_item_t got);
            out_item_t want;
            if (decoded_q.size() == 0)
            begin
                $error("result beat with nothing expected: out_byte %h error_kind %0d",
                       got.out_byte, got.error_kind);
                failures++;
                return;
            end
            want = decoded_q.pop_front();
            beats_checked++;
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte mismatch: expected %h, got %h", want.out_byte, got.out_byte);
                failures++;
            end
            if (got.error_kind !== want.error_kind)
            begin
                $error("error_kind mismatch: expected %0d, got %0d",
                       want.error_kind, got.error_kind);
                failures++;
            end
            if (got.run_end !== want.run_end)
            begin
                $error("run_end mismatch: expected %b, got %b", want.run_end, got.run_end);
                failures++;
            end
            if (got.string_end !== want.string_end)
            begin
                $error("string_end mismatch: expected %b, got %b",
                       want.string_end, got.string_end);
                failures++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       push  = 1'b0;
    logic       full;
    in_item_t   item  = '0;
    logic       empty;
    logic       pop   = 1'b0;
    out_item_t  result;

    unescape_scoreboard board = new();

    // Chance in a hundred that the sender or the receiver sits out a cycle.
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int bytes_sent   = 0;

    // The raw string body being assembled for the next send.
    byte_q_t raw_str;

    json_string_unescape_utf8 DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Both handshakes are sampled at the rising edge, where the testbench's
    // own nonblocking drives have not yet landed. That way a beat is seen
    // exactly when the block itself takes it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.note_raw_byte(item);
            if (pop && !empty)
                board.check_decoded_beat(result);
        end
    end

    // The receiver decides afresh each cycle whether to take a beat. Pop is
    // raised whether or not a result waits, so stalls land on every phase of
    // the output run.
    initial
    begin
        forever
        begin
            @(posedge clk);
            pop <= rst_n && ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Offers one raw byte and holds it until the block takes it. Idle cycles
    // before the offer create gaps on the input side.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        item.in_byte <= b;
        item.in_last <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends the assembled body, marking its final byte as the end of string.
    task automatic send_string();
        foreach (raw_str[i])
            send_byte(raw_str[i], i == raw_str.size() - 1);
    endtask

    task automatic send_text(input string s);
        raw_str.delete();
        for (int i = 0; i < s.len(); i++)
            raw_str.insert(raw_str.size(), s[i]);
        send_string();
    endtask

    function void put_raw(logic [7:0] b);
        raw_str.insert(raw_str.size(), b);
    endfunction

    // Hex digits of either case, since the block must accept both.
    function logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = 8'h30 + n;
        else if ($urandom_range(1))
            r = 8'h61 + (n - 4'd10);
        else
            r = 8'h41 + (n - 4'd10);
        return r;
    endfunction

    function logic is_hex_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function void put_u(logic [15:0] v);
        put_raw(CH_BSLASH);
        put_raw(CH_U);
        for (int i = 3; i >= 0; i--)
            put_raw(hex_char(v[4 * i +: 4]));
    endfunction

    // Any byte but the backslash, so that it passes through as it is.
    function logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CH_BSLASH)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function logic [7:0] simple_char();
        case ($urandom_range(7))
            0:       return "\"";
            1:       return "\\";
            2:       return "/";
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            default: return "t";
        endcase
    endfunction

    function logic [7:0] unknown_escape_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c == CH_U || c == "\"" || c == "\\" || c == "/" || c == "b" ||
               c == "f" || c == "n" || c == "r" || c == "t")
            c = 8'($urandom_range(255));
        return c;
    endfunction

    function logic [15:0] high_half();
        return 16'($urandom_range(16'hDBFF, 16'hD800));
    endfunction

    function logic [15:0] low_half();
        return 16'($urandom_range(16'hDFFF, 16'hDC00));
    endfunction

    // Code points spread over the 1, 2 and 3 byte encodings and both kinds of
    // surrogate standing alone.
    function logic [15:0] random_code();
        case ($urandom_range(4))
            0:       return 16'($urandom_range(16'h007F, 16'h0000));
            1:       return 16'($urandom_range(16'h07FF, 16'h0080));
            2:       return 16'($urandom_range(16'hFFFF, 16'h0800));
            3:       return high_half();
            default: return low_half();
        endcase
    endfunction

    // Mostly well-formed bodies with random content; the rest are broken
    // escapes, truncated \u sequences, trailing backslashes and plain noise.
    function void build_random_string();
        int          tokens;
        int          pick;
        int          nd;
        logic [15:0] v;
        logic [7:0]  c;
        raw_str.delete();

        if ($urandom_range(99) < 10)
        begin
            tokens = $urandom_range(10, 1);
            repeat (tokens)
            begin
                case ($urandom_range(3))
                    0:       put_raw(CH_BSLASH);
                    1:       put_raw(CH_U);
                    2:       put_raw(hex_char(4'($urandom_range(15))));
                    default: put_raw(8'($urandom_range(255)));
                endcase
            end
            return;
        end

        tokens = $urandom_range(6, 1);
        for (int k = 0; k < tokens; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                put_raw(plain_byte());
            end
            else if (pick < 45)
            begin
                put_raw(CH_BSLASH);
                put_raw(simple_char());
            end
            else if (pick < 63)
            begin
                put_u(random_code());
            end
            else if (pick < 77)
            begin
                put_u(high_half());
                put_u(low_half());
            end
            else if (pick < 83)
            begin
                // A high half that does not get its partner. A second code of 0x800 or above
                // that is no surrogate half here gives the longest output run.
                put_u(high_half());
                if ($urandom_range(1))
                begin
                    if ($urandom_range(1))
                    begin
                        v = high_half();
                    end
                    else
                    begin
                        v = 16'($urandom_range(16'hFFFF));
                        while (v >= 16'hDC00 && v <= 16'hDFFF)
                            v = 16'($urandom_range(16'hFFFF));
                    end
                    put_u(v);
                end
                else
                begin
                    put_raw(plain_byte());
                end
            end
            else if (pick < 88)
            begin
                put_raw(CH_BSLASH);
                put_raw(unknown_escape_char());
            end
            else if (pick < 93)
            begin
                put_raw(CH_BSLASH);
                put_raw(CH_U);
                nd = $urandom_range(3);
                repeat (nd)
                    put_raw(hex_char(4'($urandom_range(15))));
                c = 8'($urandom_range(255));
                while (is_hex_char(c))
                    c = 8'($urandom_range(255));
                put_raw(c);
            end
            else if (pick < 96)
            begin
                // The string ends before the \u has its four digits.
                put_raw(CH_BSLASH);
                put_raw(CH_U);
                nd = $urandom_range(3);
                repeat (nd)
                    put_raw(hex_char(4'($urandom_range(15))));
                return;
            end
            else
            begin
                put_raw(CH_BSLASH);
                return;
            end
        end
    endfunction

    initial
    begin
        int target;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 14;
        recv_gap_pct = 73;

        // Directed strings: the byte extremes, a simple escape, a surrogate
        // pair, a lone high half followed by plain text in mixed-case hex, a
        // trailing backslash, an unknown escape with the rest of its string
        // swallowed, and a bad hex digit on the final byte.
        raw_str = {8'h00, 8'hFF};
        send_string();
        send_text("\\t");
        send_text("\\uD83D\\uDE00");
        send_text("\\uDbfFz");
        send_text("\\");
        send_text("\\qx");
        send_text("\\uAg");

        // Three passes of random strings under different pressure: a slow
        // receiver, then a slow sender, then both running flat out.
        for (int pass = 0; pass < 3; pass++)
        begin
            case (pass)
                0:
                begin
                    send_gap_pct = 14;
                    recv_gap_pct = 73;
                end
                1:
                begin
                    send_gap_pct = 73;
                    recv_gap_pct = 14;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            target = bytes_sent + RANDOM_BYTES_PER_PASS;
            while (bytes_sent < target)
            begin
                build_random_string();
                send_string();
            end
        end
        push <= 1'b0;

        // Drain whatever is still owed, then give the block time to show any
        // beat that it should not send.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Ran %0d raw bytes in %0d strings under three pressure mixes.",
                 board.bytes_in, board.strings_in);
        $display("Checked %0d decoded beats, %0d error beats, %0d four-byte sequences.",
                 board.beats_checked, board.error_beats, board.four_byte_seqs);
        if (board.failures == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
